FILE: sv/lbr_pkg.sv
// Shared types and constants of the letterbox nearest-neighbor resize block.
// Used by lbr_geom, letterbox_nearest_resize and the testbench.
`timescale 1ns / 1ps
package lbr_pkg;

   // Field and datapath widths
   localparam int SRC_W = 9;           // source size registers
   localparam int DST_W = 11;          // target size registers
   localparam int POS_W = 10;          // col and row
   localparam int PIX_W = 8;           // one color byte
   localparam int CH_W  = 16;          // one normalized channel
   localparam int NUM_W = 11;          // scale numerator
   localparam int DEN_W = 9;           // scale denominator
   localparam int RSZ_W = 11;          // resized size
   localparam int PAD_W = 10;          // pad
   localparam int MAP_W = POS_W + DEN_W;   // position times denominator
   localparam int GN_W  = 20;          // geometry dividend 2*s*num+den
   localparam int GD_W  = DEN_W + 1;   // geometry divisor 2*den
   localparam int PROD_W = DST_W + SRC_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = DST_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 2'd3;

   // Request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Geometry sequencer states
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CMP  = 6'b000010,
      ST_SEL  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_PAD  = 6'b100000
   } state_type;

   // Letterbox geometry plus the clamped live sizes
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [RSZ_W-1:0] rw;
      logic [RSZ_W-1:0] rh;
      logic [PAD_W-1:0] pl;
      logic [PAD_W-1:0] pt;
      logic [SRC_W-1:0] sw;
      logic [SRC_W-1:0] sh;
      logic [DST_W-1:0] dw;
      logic [DST_W-1:0] dh;
   } geom_type;

   // Per-transaction sideband that rides along the mapping pipeline
   typedef struct packed {
      logic             rd;    // read (else load)
      logic             ok;    // read inside window, or load inside source
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } side_type;

endpackage

FILE: sv/letterbox_nearest_resize.sv
// Letterbox nearest-neighbor resize: top level with the source frame memory.
// Depends on lbr_pkg, lbr_geom and lbr_pdiv.
//
// Channel | Direction | Handshake         | Payload
// req     | in        | tvalid/tready     | tuser kind, tdata col,row,B,G,R
// rsp     | out       | tvalid/tready     | tuser in_image, tdata R,G,B
// csr     | in        | wen, no handshake | index, wdata
//
// One transaction per cycle sustained while rsp is not stalled and the geometry
// is settled; a read passes offset, multiply, 19 divider stages, address, memory
// and output. After reset and after any register write the geometry unit runs
// compare, select, start, two parallel 20-step dividers and pads; req_tready
// stays low meanwhile.
// A stalled rsp holds the whole pipeline in place; loads write the frame
// memory at the same stage where reads read it, so order is kept.
`timescale 1ns / 1ps
module letterbox_nearest_resize
   import lbr_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_DST_WIDTH  = 1024,
   parameter int MAX_DST_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // col, row, in_blue, in_green, in_red
   input  logic                  req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // out_red, out_green, out_blue
   output logic                  rsp_tuser,   // in_image
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SIDE_W = $bits(side_type);

   geom_type         geom;
   logic             geom_busy;
   logic             en, accept;
   side_type         s0_side;
   logic [POS_W-1:0] s0_dx, s0_dy;
   logic             a_v_ff;
   side_type         a_side_ff;
   logic [POS_W-1:0] a_dx_ff, a_dy_ff;
   logic             b_v_ff;
   side_type         b_side_ff;
   logic [MAP_W-1:0] b_mx_ff, b_my_ff;
   logic             c_v;
   logic [SIDE_W-1:0] c_side_bits;
   side_type         c_side;
   logic [MAP_W-1:0] c_qx, c_qy;
   logic [SRC_W-1:0] sx, sy;
   logic [AW-1:0]    addr;
   logic             d_we_ff, d_rd_ff, d_ok_ff;
   logic [AW-1:0]    d_addr_ff;
   logic [23:0]      d_wdata_ff;
   logic [23:0]      mem [DEPTH];
   logic [23:0]      e_data_ff;
   logic             e_v_ff, e_ok_ff;
   logic             rsp_v_ff;
   logic [47:0]      rsp_data_ff;
   logic             rsp_img_ff;

   lbr_geom #(
      .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
      .MAX_DST_WIDTH(MAX_DST_WIDTH), .MAX_DST_HEIGHT(MAX_DST_HEIGHT)
   ) u_geom (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .busy(geom_busy), .geom(geom)
   );

   // Pipeline moves unless a result waits unclaimed
   assign en         = !rsp_v_ff || rsp_tready;
   assign req_tready = en && !geom_busy;
   assign accept     = req_tvalid && req_tready;

   // Unpack, offset into the window and classify
   always_comb begin
      s0_side.rd    = req_tuser == REQ_READ;
      s0_side.col   = req_tdata[9:0];
      s0_side.row   = req_tdata[19:10];
      s0_side.blue  = req_tdata[27:20];
      s0_side.green = req_tdata[35:28];
      s0_side.red   = req_tdata[43:36];
      s0_dx = s0_side.col - geom.pl;
      s0_dy = s0_side.row - geom.pt;
      if (s0_side.rd) begin
         s0_side.ok = ({1'b0, s0_side.col} < geom.dw) &&
                      ({1'b0, s0_side.row} < geom.dh) &&
                      (s0_side.col >= geom.pl) && ({1'b0, s0_dx} < geom.rw) &&
                      (s0_side.row >= geom.pt) && ({1'b0, s0_dy} < geom.rh);
      end else begin
         s0_side.ok = (s0_side.col < POS_W'(geom.sw)) &&
                      (s0_side.row < POS_W'(geom.sh));
      end
   end

   // Stage A: capture; stage B: scale by the denominator
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= accept;
         b_v_ff <= a_v_ff;
      end
      if (en) begin
         a_side_ff <= s0_side;
         a_dx_ff   <= s0_dx;
         a_dy_ff   <= s0_dy;
         b_side_ff <= a_side_ff;
         b_mx_ff   <= a_dx_ff * geom.den;
         b_my_ff   <= a_dy_ff * geom.den;
      end
   end

   lbr_pdiv #(.NW(MAP_W), .DW(NUM_W), .SIDE_W(SIDE_W)) u_pdiv (
      .clock(clock), .reset(reset), .en(en), .in_valid(b_v_ff),
      .in_side(b_side_ff), .in_dvd_x(b_mx_ff), .in_dvd_y(b_my_ff),
      .divisor(geom.num), .out_valid(c_v), .out_side(c_side_bits),
      .out_q_x(c_qx), .out_q_y(c_qy)
   );
   assign c_side = side_type'(c_side_bits);

   // Clamp to the source edge and form the frame address
   always_comb begin
      sx = (c_qx >= MAP_W'(geom.sw)) ? SRC_W'(geom.sw - 1'b1) : c_qx[SRC_W-1:0];
      sy = (c_qy >= MAP_W'(geom.sh)) ? SRC_W'(geom.sh - 1'b1) : c_qy[SRC_W-1:0];
      if (c_side.rd) begin
         addr = AW'(int'(sy) * MAX_SRC_WIDTH + int'(sx));
      end else begin
         addr = AW'(int'(c_side.row) * MAX_SRC_WIDTH + int'(c_side.col));
      end
   end

   // Stage D: address and write data
   always_ff @(posedge clock) begin
      if (reset) begin
         d_we_ff <= 1'b0;
         d_rd_ff <= 1'b0;
      end else if (en) begin
         d_we_ff <= c_v && !c_side.rd && c_side.ok;
         d_rd_ff <= c_v && c_side.rd;
      end
      if (en) begin
         d_ok_ff    <= c_side.ok;
         d_addr_ff  <= addr;
         d_wdata_ff <= {c_side.red, c_side.green, c_side.blue};
      end
   end

   // Stage E: frame memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (d_we_ff) mem[d_addr_ff] <= d_wdata_ff;
         e_data_ff <= mem[d_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en) begin
         e_v_ff <= d_rd_ff;
      end
      if (en) e_ok_ff <= d_ok_ff;
   end

   // Output register: byte times 257, zero outside the window
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= e_v_ff;
      end
      if (en) begin
         rsp_img_ff <= e_ok_ff;
         if (e_ok_ff) begin
            rsp_data_ff <= {e_data_ff[7:0], e_data_ff[7:0],
                            e_data_ff[15:8], e_data_ff[15:8],
                            e_data_ff[23:16], e_data_ff[23:16]};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_img_ff;

   // No transaction enters while the geometry is being worked out
   assert property (@(posedge clock) disable iff (reset)
      geom_busy |-> !accept)
      else $error("request accepted during geometry update");

   // Padding results carry no color
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("padding result with nonzero color");

   // Settled geometry never has a zero scale
   assert property (@(posedge clock) disable iff (reset)
      !geom_busy |-> (geom.num != '0 && geom.den != '0))
      else $error("zero scale in settled geometry");

   // A register write restarts the geometry unit
   assert property (@(posedge clock) disable iff (reset)
      csr_wen |=> geom_busy)
      else $error("geometry not restarted after register write");
endmodule

FILE: sv/lbr_idiv.sv
// Iterative restoring divider, one quotient bit per cycle.
// Used by lbr_geom; no package dependencies.
`timescale 1ns / 1ps
module lbr_idiv #(
   parameter int NW = 20,
   parameter int DW = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);
   localparam int CNT_W = $clog2(NW + 1);

   logic              run_ff, run_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [NW-1:0]     dvd_ff, dvd_in;
   logic [DW:0]       trial;
   logic              qbit;

   // One compare and subtract step
   always_comb begin
      trial  = {rem_ff, dvd_ff[NW-1]};
      qbit   = trial >= {1'b0, divisor};
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(NW);
         rem_in = '0;
         dvd_in = dividend;
      end else if (run_ff) begin
         rem_in = qbit ? DW'(trial - {1'b0, divisor}) : DW'(trial);
         dvd_in = {dvd_ff[NW-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign done     = !run_ff && !start;
   assign quotient = dvd_ff;
endmodule

FILE: sv/lbr_geom.sv
// Size registers and the letterbox geometry sequencer.
// Depends on lbr_pkg and lbr_idiv.
`timescale 1ns / 1ps
module lbr_geom
   import lbr_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_DST_WIDTH  = 1024,
   parameter int MAX_DST_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  busy,
   output geom_type              geom
);
   logic [SRC_W-1:0] src_w_ff, src_h_ff;
   logic [DST_W-1:0] dst_w_ff, dst_h_ff;
   logic [SRC_W-1:0] sw, sh;
   logic [DST_W-1:0] dw, dh;
   state_type        state_ff, state_in;
   logic [PROD_W-1:0] prod_h_ff, prod_w_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [RSZ_W-1:0] rw_ff, rh_ff;
   logic [PAD_W-1:0] pl_ff, pt_ff;
   logic             start, done_w, done_h;
   logic [GN_W-1:0]  dvd_w, dvd_h, q_w, q_h;
   logic [GD_W-1:0]  dvs;

   // Clamp live registers into their legal ranges
   always_comb begin
      sw = (src_w_ff == '0) ? SRC_W'(1) :
           (src_w_ff > MAX_SRC_WIDTH)  ? SRC_W'(MAX_SRC_WIDTH)  : src_w_ff;
      sh = (src_h_ff == '0) ? SRC_W'(1) :
           (src_h_ff > MAX_SRC_HEIGHT) ? SRC_W'(MAX_SRC_HEIGHT) : src_h_ff;
      dw = (dst_w_ff == '0) ? DST_W'(1) :
           (dst_w_ff > MAX_DST_WIDTH)  ? DST_W'(MAX_DST_WIDTH)  : dst_w_ff;
      dh = (dst_h_ff == '0) ? DST_W'(1) :
           (dst_h_ff > MAX_DST_HEIGHT) ? DST_W'(MAX_DST_HEIGHT) : dst_h_ff;
   end

   // Resized size per axis: (2*s*num + den) / (2*den)
   assign start = state_ff == ST_MUL;
   assign dvd_w = GN_W'({sw, 1'b0} * num_ff) + GN_W'(den_ff);
   assign dvd_h = GN_W'({sh, 1'b0} * num_ff) + GN_W'(den_ff);
   assign dvs   = {den_ff, 1'b0};

   lbr_idiv #(.NW(GN_W), .DW(GD_W)) u_div_w (
      .clock(clock), .reset(reset), .start(start), .dividend(dvd_w),
      .divisor(dvs), .done(done_w), .quotient(q_w)
   );
   lbr_idiv #(.NW(GN_W), .DW(GD_W)) u_div_h (
      .clock(clock), .reset(reset), .start(start), .dividend(dvd_h),
      .divisor(dvs), .done(done_h), .quotient(q_h)
   );

   // Advance the sequencer; any register write restarts it
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: state_in = ST_IDLE;
         ST_CMP:  state_in = ST_SEL;
         ST_SEL:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  if (done_w && done_h) state_in = ST_PAD;
         ST_PAD:  state_in = ST_IDLE;
         default: state_in = ST_CMP;
      endcase
      if (csr_wen) state_in = ST_CMP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CMP;
         src_w_ff <= SRC_W'(256);
         src_h_ff <= SRC_W'(256);
         dst_w_ff <= DST_W'(640);
         dst_h_ff <= DST_W'(640);
         num_ff   <= NUM_W'(1);
         den_ff   <= DEN_W'(1);
         rw_ff    <= '0;
         rh_ff    <= '0;
         pl_ff    <= '0;
         pt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         // Take register writes
         if (csr_wen) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[SRC_W-1:0];
               CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[SRC_W-1:0];
               CSR_DST_WIDTH:  dst_w_ff <= csr_wdata[DST_W-1:0];
               CSR_DST_HEIGHT: dst_h_ff <= csr_wdata[DST_W-1:0];
               default: ;
            endcase
         end
         // Pick the smaller ratio, height on a tie
         if (state_ff == ST_SEL) begin
            if (prod_h_ff <= prod_w_ff) begin
               num_ff <= NUM_W'(dh);
               den_ff <= DEN_W'(sh);
            end else begin
               num_ff <= NUM_W'(dw);
               den_ff <= DEN_W'(sw);
            end
         end
         // Clamp resized sizes to the target
         if (state_ff == ST_DIV && done_w && done_h) begin
            rw_ff <= (q_w > GN_W'(dw)) ? RSZ_W'(dw) : q_w[RSZ_W-1:0];
            rh_ff <= (q_h > GN_W'(dh)) ? RSZ_W'(dh) : q_h[RSZ_W-1:0];
         end
         // Split the slack
         if (state_ff == ST_PAD) begin
            pl_ff <= PAD_W'((RSZ_W'(dw) - rw_ff) >> 1);
            pt_ff <= PAD_W'((RSZ_W'(dh) - rh_ff) >> 1);
         end
      end
      // Cross products for the ratio compare
      if (state_ff == ST_CMP) begin
         prod_h_ff <= dh * sw;
         prod_w_ff <= dw * sh;
      end
   end

   assign busy = state_ff != ST_IDLE;

   always_comb begin
      geom.num = num_ff;
      geom.den = den_ff;
      geom.rw  = rw_ff;
      geom.rh  = rh_ff;
      geom.pl  = pl_ff;
      geom.pt  = pt_ff;
      geom.sw  = sw;
      geom.sh  = sh;
      geom.dw  = dw;
      geom.dh  = dh;
   end
endmodule

FILE: sv/lbr_pdiv.sv
// Pipelined restoring divider for the x and y maps, one bit per stage.
// Both dividends share a divisor; a sideband word travels alongside.
`timescale 1ns / 1ps
module lbr_pdiv #(
   parameter int NW     = 19,
   parameter int DW     = 11,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [SIDE_W-1:0] in_side,
   input  logic [NW-1:0]     in_dvd_x,
   input  logic [NW-1:0]     in_dvd_y,
   input  logic [DW-1:0]     divisor,
   output logic              out_valid,
   output logic [SIDE_W-1:0] out_side,
   output logic [NW-1:0]     out_q_x,
   output logic [NW-1:0]     out_q_y
);
   logic              v_ff    [NW];
   logic [SIDE_W-1:0] side_ff [NW];
   logic [DW-1:0]     rx_ff   [NW];
   logic [DW-1:0]     ry_ff   [NW];
   logic [NW-1:0]     dx_ff   [NW];
   logic [NW-1:0]     dy_ff   [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic              pv;
      logic [SIDE_W-1:0] pside;
      logic [DW-1:0]     prx, pry;
      logic [NW-1:0]     pdx, pdy;
      logic [DW:0]       tx, ty;
      logic              bx, by;

      // Select the previous stage or the input
      if (s == 0) begin : g_first
         assign pv    = in_valid;
         assign pside = in_side;
         assign prx   = '0;
         assign pry   = '0;
         assign pdx   = in_dvd_x;
         assign pdy   = in_dvd_y;
      end else begin : g_next
         assign pv    = v_ff[s-1];
         assign pside = side_ff[s-1];
         assign prx   = rx_ff[s-1];
         assign pry   = ry_ff[s-1];
         assign pdx   = dx_ff[s-1];
         assign pdy   = dy_ff[s-1];
      end

      assign tx = {prx, pdx[NW-1]};
      assign ty = {pry, pdy[NW-1]};
      assign bx = tx >= {1'b0, divisor};
      assign by = ty >= {1'b0, divisor};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= pv;
         end
         if (en) begin
            side_ff[s] <= pside;
            rx_ff[s]   <= bx ? DW'(tx - {1'b0, divisor}) : DW'(tx);
            ry_ff[s]   <= by ? DW'(ty - {1'b0, divisor}) : DW'(ty);
            dx_ff[s]   <= {pdx[NW-2:0], bx};
            dy_ff[s]   <= {pdy[NW-2:0], by};
         end
      end
   end

   assign out_valid = v_ff[NW-1];
   assign out_side  = side_ff[NW-1];
   assign out_q_x   = dx_ff[NW-1];
   assign out_q_y   = dy_ff[NW-1];
endmodule

FILE: sim/letterbox_nearest_resize_test.sv
// Self-checking testbench of the letterbox nearest-neighbor resize block.
// Depends on lbr_pkg and letterbox_nearest_resize; runs phases of register settings,
// each with source loads and destination reads checked against a built-in predictor.
`timescale 1ns / 1ps
module letterbox_nearest_resize_test;
   import lbr_pkg::*;

   localparam int SRC_MAX = 256;
   localparam int DST_MAX = 1024;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            in_image;
   } pixel_type;

   typedef struct {
      logic             kind;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      bit               typed;
      pixel_type        want;
   } stim_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;   // col, row, in_blue, in_green, in_red
   logic                  req_tuser;   // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [47:0]           rsp_tdata;   // out_red, out_green, out_blue
   logic                  rsp_tuser;   // in_image
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   letterbox_nearest_resize i_dut (.*);

   // Predictor state: registers, frame store and derived letterbox geometry
   logic [SRC_W-1:0] reg_sw, reg_sh;
   logic [DST_W-1:0] reg_dw, reg_dh;
   logic [23:0]      frame_bgr [SRC_MAX*SRC_MAX];
   bit               frame_set [SRC_MAX*SRC_MAX];
   int unsigned      sw, sh, dw, dh, num, den, rw, rh, pl, pt;

   pixel_type pending_pixels [$];
   int        errors = 0;
   int        loads = 0;
   int        reads = 0;
   int        phases = 0;
   int        cycles = 0;
   bit        tx_gaps = 1;
   bit        rx_gaps = 1;

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      return v < 1 ? 1 : (v > hi ? hi : v);
   endfunction

   // Recompute the letterbox geometry from the register copy
   function automatic void update_geometry();
      sw = clamp_size(reg_sw, SRC_MAX);
      sh = clamp_size(reg_sh, SRC_MAX);
      dw = clamp_size(reg_dw, DST_MAX);
      dh = clamp_size(reg_dh, DST_MAX);
      if (longint'(dh) * sw <= longint'(dw) * sh) begin
         num = dh;
         den = sh;
      end else begin
         num = dw;
         den = sw;
      end
      rw = (2 * sw * num + den) / (2 * den);
      rh = (2 * sh * num + den) / (2 * den);
      if (rw > dw) rw = dw;
      if (rh > dh) rh = dh;
      pl = (dw - rw) / 2;
      pt = (dh - rh) / 2;
   endfunction

   // Map a destination position to a source entry; returns 0 for padding
   function automatic bit map_position(int unsigned c, int unsigned r, output int unsigned addr);
      int unsigned sx, sy;
      addr = 0;
      if (!(c < dw && r < dh && c >= pl && c - pl < rw && r >= pt && r - pt < rh))
         return 0;
      sx = ((c - pl) * den) / num;
      sy = ((r - pt) * den) / num;
      if (sx >= sw) sx = sw - 1;
      if (sy >= sh) sy = sh - 1;
      addr = sy * SRC_MAX + sx;
      return 1;
   endfunction

   // Apply one accepted transaction; returns the expected pixel for reads
   function automatic pixel_type predict_pixel(stim_type s);
      pixel_type   p;
      int unsigned addr;
      p = '0;
      if (s.kind == REQ_LOAD) begin
         if (s.col < sw && s.row < sh) begin
            frame_bgr[s.row*SRC_MAX + s.col] = {s.red, s.green, s.blue};
            frame_set[s.row*SRC_MAX + s.col] = 1;
         end
      end else if (map_position(s.col, s.row, addr)) begin
         p.red      = frame_bgr[addr][23:16] * 16'd257;
         p.green    = frame_bgr[addr][15:8] * 16'd257;
         p.blue     = frame_bgr[addr][7:0] * 16'd257;
         p.in_image = 1;
      end
      return p;
   endfunction

   // Clock and one reset pulse
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (5) @(posedge clock);
      reset <= 0;
   end

   // Cycle guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("letterbox_nearest_resize test failed");
         $finish;
      end
   end

   // Send one transaction and record what it should produce
   task automatic send_item(stim_type s);
      int gap;
      pixel_type p;
      gap = tx_gaps ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= s.kind;
      req_tdata  <= {4'd0, s.red, s.green, s.blue, s.row, s.col};
      do @(posedge clock); while (!req_tready);
      p = predict_pixel(s);
      if (s.kind == REQ_READ) begin
         pending_pixels.push_back(s.typed ? s.want : p);
         reads++;
      end else begin
         loads++;
      end
   endtask

   // Hold off until all reads answered and the pipeline has drained
   task automatic drain();
      req_tvalid <= 0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_sizes(int unsigned a, int unsigned b, int unsigned c, int unsigned d);
      drain();
      csr_wen <= 1;
      csr_index <= CSR_SRC_WIDTH;  csr_wdata <= CSR_DATA_W'(a); @(posedge clock);
      csr_index <= CSR_SRC_HEIGHT; csr_wdata <= CSR_DATA_W'(b); @(posedge clock);
      csr_index <= CSR_DST_WIDTH;  csr_wdata <= CSR_DATA_W'(c); @(posedge clock);
      csr_index <= CSR_DST_HEIGHT; csr_wdata <= CSR_DATA_W'(d); @(posedge clock);
      csr_wen <= 0;
      reg_sw = a[SRC_W-1:0];
      reg_sh = b[SRC_W-1:0];
      reg_dw = c[DST_W-1:0];
      reg_dh = d[DST_W-1:0];
      update_geometry();
      phases++;
   endtask

   function automatic stim_type random_load(int unsigned c, int unsigned r);
      stim_type s;
      s.kind = REQ_LOAD;
      s.col = POS_W'(c);
      s.row = POS_W'(r);
      s.blue = PIX_W'($urandom);
      s.green = PIX_W'($urandom);
      s.red = PIX_W'($urandom);
      s.typed = 0;
      s.want = '0;
      return s;
   endfunction

   // One phase of random traffic under the current setting
   task automatic random_phase(int count);
      stim_type    s;
      int unsigned addr, pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_item(random_load($urandom_range(0, sw - 1), $urandom_range(0, sh - 1)));
         end else if (pick < 42) begin
            send_item(random_load($urandom_range(0, 1023), $urandom_range(0, 1023)));
         end else begin
            s = random_load(0, 0);
            s.kind = REQ_READ;
            if (pick < 92) begin
               s.col = POS_W'($urandom_range(0, dw - 1));
               s.row = POS_W'($urandom_range(0, dh - 1));
            end else begin
               s.col = POS_W'($urandom_range(0, 1023));
               s.row = POS_W'($urandom_range(0, 1023));
            end
            // Fill the source entry first so no unloaded entry is read
            if (map_position(s.col, s.row, addr) && !frame_set[addr])
               send_item(random_load(addr % SRC_MAX, addr / SRC_MAX));
            send_item(s);
         end
         if (i == count / 2 && phases == 3) drain();
      end
   endtask

   // Response side: random backpressure and in-order compare
   initial begin
      int        gap;
      pixel_type got, want;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         gap = rx_gaps ? $urandom_range(0, 13) : 0;
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser};
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (got.red !== want.red)
               $display("%0t: red expected %h actual %h", $time, want.red, got.red);
            if (got.green !== want.green)
               $display("%0t: green expected %h actual %h", $time, want.green, got.green);
            if (got.blue !== want.blue)
               $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
            if (got.in_image !== want.in_image)
               $display("%0t: in_image expected %b actual %b", $time,
                        want.in_image, got.in_image);
            if (got !== want) errors++;
         end
      end
   end

   // Stimulus
   initial begin
      stim_type directed [13];
      int       w;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = REQ_LOAD;
      csr_wen = 0;
      csr_index = CSR_SRC_WIDTH;
      csr_wdata = '0;
      reg_sw = 256;
      reg_sh = 256;
      reg_dw = 640;
      reg_dh = 640;
      update_geometry();
      foreach (directed[k]) directed[k] = random_load(0, 0);
      // Reset setting: 256x256 into 640x640, scale 5/2, no padding
      directed[0]  = '{REQ_LOAD, 0, 0, 8'h00, 8'hFF, 8'h80, 0, '0};
      directed[1]  = '{REQ_LOAD, 255, 255, 8'hFF, 8'hFF, 8'hFF, 0, '0};
      directed[2]  = '{REQ_LOAD, 1023, 1023, 8'h55, 8'h55, 8'h55, 0, '0};
      directed[3]  = '{REQ_LOAD, 128, 0, 8'h12, 8'h34, 8'h56, 0, '0};
      directed[4]  = '{REQ_READ, 0, 0, 0, 0, 0, 1, '{16'h8080, 16'hFFFF, 16'h0000, 1}};
      directed[5]  = '{REQ_READ, 639, 639, 0, 0, 0, 1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1}};
      directed[6]  = '{REQ_READ, 1023, 1023, 8'hFF, 8'hFF, 8'hFF, 1, '0};
      directed[7]  = '{REQ_READ, 640, 0, 0, 0, 0, 1, '0};
      directed[8]  = '{REQ_READ, 320, 0, 0, 0, 0, 1, '{16'h5656, 16'h3434, 16'h1212, 1}};
      directed[9]  = '{REQ_LOAD, 255, 0, 8'hFF, 8'h00, 8'hAA, 0, '0};
      directed[10] = '{REQ_READ, 639, 0, 0, 0, 0, 1, '{16'hAAAA, 16'h0000, 16'hFFFF, 1}};
      directed[11] = '{REQ_LOAD, 0, 255, 8'h03, 8'h02, 8'h01, 0, '0};
      directed[12] = '{REQ_READ, 0, 639, 0, 0, 0, 1, '{16'h0101, 16'h0202, 16'h0303, 1}};
      @(negedge reset);
      @(posedge clock);
      foreach (directed[k]) send_item(directed[k]);

      // Settings: extremes, clamped values, an empty window, then random ones
      write_sizes(1, 1, 1, 1);             random_phase(60);
      write_sizes(256, 256, 1024, 1024);   random_phase(160);
      write_sizes(256, 1, 1, 1);           random_phase(60);
      tx_gaps = 0; rx_gaps = 0;
      write_sizes(1, 256, 1024, 1024);     random_phase(120);
      write_sizes(0, 0, 0, 0);             random_phase(60);
      tx_gaps = 1;
      write_sizes(511, 3, 2047, 2047);     random_phase(120);
      rx_gaps = 1;
      write_sizes(512 + 7, 1024 + 5, 1, 1024); random_phase(80);
      for (int p = 0; p < 9; p++) begin
         tx_gaps = p % 3 != 0;
         rx_gaps = p % 4 != 1;
         w = $urandom_range(1, 24);
         write_sizes((p == 8) ? 256 : w | ($urandom_range(0, 3) << 9),
                     $urandom_range(1, 24) | ($urandom_range(0, 3) << 9),
                     $urandom_range(1, 2047), $urandom_range(1, 2047));
         random_phase(110);
      end
      drain();

      $display("Covered %0d loads and %0d reads over %0d register settings.",
               loads, reads, phases);
      if (errors == 0 && pending_pixels.size() == 0)
         $display("letterbox_nearest_resize test passed");
      else
         $display("letterbox_nearest_resize test failed");
      $finish;
   end

endmodule
